// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables checking.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/amr_pkg.sv =====
// Package of the axis mean reducer: default sizes, configuration codes
// and the controller state type. No dependencies.
package amr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAX_STRIDE_DEF = 1024;
    localparam int MAX_AXIS_DEF   = 4096;

    // Configuration port and register field widths.
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int STRIDE_RAW_W = 11;
    localparam int AXIS_RAW_W   = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER_STRIDE = 8'd0,
        CFG_AXIS_LENGTH  = 8'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== design/amr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module amr_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/axis_mean_reducer.sv =====
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   sample
// m_axis    out        m_axis_tvalid/m_axis_tready   mean_value, stride_position
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One beat is in work at a time. A beat that is not on the last row of the axis
// has its partial sum read from the RAM, then added to and written back.
// A beat on the last row adds a restoring division with a DATA_WIDTH+clog2(MAX_AXIS)
// bit quotient (44 bits by default), then a load of the output register once it is free.
// The output register lets the next beat in while a mean waits on m_axis_tready.
// Reset clears counters and configuration; the partial sum RAM is not cleared,
// since the first row of every block loads its entries before any add.
// Depends on amr_pkg and amr_ram.
module axis_mean_reducer import amr_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAX_STRIDE = MAX_STRIDE_DEF,
    parameter int MAX_AXIS   = MAX_AXIS_DEF,
    localparam int POS_W     = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1,
    localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((DATA_WIDTH + POS_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // mean_value, stride_position
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AX_CNT_W  = (MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 1;
    localparam int SUM_W     = DATA_WIDTH + ((MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 0);
    localparam int STRIDE_CW = $clog2(MAX_STRIDE + 1);
    localparam int AXIS_CW   = $clog2(MAX_AXIS + 1);
    localparam int DIV_CW    = $clog2(SUM_W + 1);
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(SUM_W - 1);

    state_t state_reg, state_next;

    logic [STRIDE_CW-1:0] stride_eff_reg;
    logic [AXIS_CW-1:0]   axis_eff_reg;
    logic [POS_W-1:0]     stride_cnt_reg;
    logic [AX_CNT_W-1:0]  axis_cnt_reg;

    logic [SUM_W-1:0]     sample_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 first_reg;
    logic                 last_reg;

    logic [AXIS_CW-1:0]   rem_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic                 neg_reg;
    logic [DIV_CW-1:0]    div_cnt_reg;

    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;

    logic                 s_accept;
    logic                 cfg_wr;
    logic                 cfg_known;
    logic                 stride_wrap;
    logic                 axis_wrap;
    logic                 ram_we;
    logic                 div_load;
    logic                 div_step;
    logic                 out_free;
    logic                 out_load;
    logic [SUM_W-1:0]     ram_rdata;
    logic [SUM_W-1:0]     acc_sum;
    logic [SUM_W-1:0]     acc_mag;
    logic [AXIS_CW:0]     rem_shift;
    logic                 rem_ge;
    logic [SUM_W-1:0]     quo_signed;
    logic [STRIDE_RAW_W-1:0] stride_raw;
    logic [AXIS_RAW_W-1:0]   axis_raw;
    logic [STRIDE_CW-1:0] stride_new;
    logic [AXIS_CW-1:0]   axis_new;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == CFG_INNER_STRIDE) || (cfg_index == CFG_AXIS_LENGTH);
    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A zero register value acts as one, and values above the maximum saturate.
    assign stride_raw = cfg_data[STRIDE_RAW_W-1:0];
    assign axis_raw   = cfg_data[AXIS_RAW_W-1:0];

    always_comb begin
        if (stride_raw == '0) begin
            stride_new = STRIDE_CW'(1);
        end else if (32'(stride_raw) > 32'(MAX_STRIDE)) begin
            stride_new = STRIDE_CW'(MAX_STRIDE);
        end else begin
            stride_new = STRIDE_CW'(stride_raw);
        end
        if (axis_raw == '0) begin
            axis_new = AXIS_CW'(1);
        end else if (32'(axis_raw) > 32'(MAX_AXIS)) begin
            axis_new = AXIS_CW'(MAX_AXIS);
        end else begin
            axis_new = AXIS_CW'(axis_raw);
        end
    end

    assign stride_wrap = (32'(stride_cnt_reg) + 32'd1) >= 32'(stride_eff_reg);
    assign axis_wrap   = (32'(axis_cnt_reg) + 32'd1) >= 32'(axis_eff_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_eff_reg <= STRIDE_CW'(1);
            axis_eff_reg   <= AXIS_CW'(1);
            stride_cnt_reg <= '0;
            axis_cnt_reg   <= '0;
        end else if (cfg_wr && cfg_known) begin
            if (cfg_index == CFG_INNER_STRIDE) begin
                stride_eff_reg <= stride_new;
            end else begin
                axis_eff_reg <= axis_new;
            end
            stride_cnt_reg <= '0;
            axis_cnt_reg   <= '0;
        end else if (s_accept) begin
            if (stride_wrap) begin
                stride_cnt_reg <= '0;
                axis_cnt_reg   <= axis_wrap ? '0 : axis_cnt_reg + AX_CNT_W'(1);
            end else begin
                stride_cnt_reg <= stride_cnt_reg + POS_W'(1);
            end
        end
    end

    // Beat capture; the RAM read of the partial sum is issued in the same cycle.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= SUM_W'(signed'(s_axis_tdata[DATA_WIDTH-1:0]));
            pos_reg    <= stride_cnt_reg;
            first_reg  <= (axis_cnt_reg == '0);
            last_reg   <= axis_wrap;
        end
    end

    amr_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_STRIDE)
    ) u_sums (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (acc_sum),
        .re    (s_accept),
        .raddr (stride_cnt_reg),
        .rdata (ram_rdata)
    );

    assign acc_sum = first_reg ? sample_reg : ram_rdata + sample_reg;
    assign acc_mag = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : acc_sum;

    // Restoring division of the magnitude, one quotient bit per cycle.
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, axis_eff_reg};

    always_ff @(posedge aclk) begin
        if (div_load) begin
            rem_reg     <= '0;
            quo_reg     <= acc_mag;
            neg_reg     <= acc_sum[SUM_W-1];
            div_cnt_reg <= '0;
        end else if (div_step) begin
            rem_reg     <= rem_ge ? AXIS_CW'(rem_shift - {1'b0, axis_eff_reg})
                                  : rem_shift[AXIS_CW-1:0];
            quo_reg     <= {quo_reg[SUM_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CW'(1);
        end
    end

    assign quo_signed = neg_reg ? SUM_W'(-quo_reg) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= OUT_W'({pos_reg, quo_signed[DATA_WIDTH-1:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                state_next = last_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        div_load      = 1'b0;
        div_step      = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_ACC: begin
                ram_we   = 1'b1;
                div_load = last_reg;
            end
            ST_DIV: begin
                div_step = 1'b1;
            end
            ST_OUT: begin
                out_load = out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/amr_checker.sv =====
// Port-level checker for the axis mean reducer, bound to the top level.
// Depends on amr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module amr_checker import amr_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAX_STRIDE = MAX_STRIDE_DEF,
    localparam int POS_W     = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1,
    localparam int OUT_W     = ((DATA_WIDTH + POS_W + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // A stalled result beat stays offered and unchanged.
    `ASSERT_CLK(a_m_hold_valid, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "m_axis beat dropped while stalled")
    `ASSERT_CLK(a_m_hold_data, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "m_axis data changed while stalled")

    // The partial sum is read and written back before another beat enters.
    `ASSERT_CLK(a_one_in_flight, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted during read-modify-write")

    // A new mean comes only out of the divider, while input is held off.
    `ASSERT_CLK(a_result_from_div, aclk, aresetn, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared without a division")

endmodule

bind axis_mean_reducer amr_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_STRIDE (MAX_STRIDE)
) u_amr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/mean_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for axis_mean_reducer: follows register writes and input beats,
// predicts every mean with its stride position and compares the result beats.
// Depends on amr_pkg.
module mean_checker import amr_pkg::*; #(
    parameter int IN_W  = 32,
    parameter int OUT_W = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // sample
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_W-1:0]      m_axis_tdata,   // mean_value, stride_position
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    means_checked
);

    localparam int POS_W = $clog2(MAX_STRIDE_DEF);

    typedef struct packed {
        logic [DATA_WIDTH_DEF-1:0] mean;
        logic [POS_W-1:0]          pos;
    } mean_result_t;

    mean_result_t            expected_means[$];
    longint                  column_sums[MAX_STRIDE_DEF];
    logic [STRIDE_RAW_W-1:0] stride_setting;
    logic [AXIS_RAW_W-1:0]   axis_setting;
    int                      stride_pos;
    int                      row_pos;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_INNER_STRIDE) begin
            stride_setting = data[STRIDE_RAW_W-1:0];
        end else if (idx == CFG_AXIS_LENGTH) begin
            axis_setting = data[AXIS_RAW_W-1:0];
        end else begin
            return;
        end
        // Any valid register write restarts the block at its first element.
        stride_pos = 0;
        row_pos = 0;
    endtask

    task automatic predict_mean(input logic [DATA_WIDTH_DEF-1:0] word);
        int           stride;
        int           axis;
        longint       acc;
        longint       quotient;
        mean_result_t entry;
        stride = (stride_setting == 0) ? 1 :
                 (stride_setting > MAX_STRIDE_DEF) ? MAX_STRIDE_DEF : int'(stride_setting);
        axis = (axis_setting == 0) ? 1 :
               (axis_setting > MAX_AXIS_DEF) ? MAX_AXIS_DEF : int'(axis_setting);
        if (row_pos == 0) begin
            acc = longint'(signed'(word));
        end else begin
            acc = column_sums[stride_pos] + longint'(signed'(word));
        end
        column_sums[stride_pos] = acc;
        if (row_pos + 1 >= axis) begin
            // Signed division in SystemVerilog already truncates toward zero.
            quotient = acc / longint'(axis);
            entry.mean = quotient[DATA_WIDTH_DEF-1:0];
            entry.pos = stride_pos[POS_W-1:0];
            expected_means = {expected_means, entry};
        end
        if (stride_pos + 1 >= stride) begin
            stride_pos = 0;
            row_pos = (row_pos + 1 >= axis) ? 0 : row_pos + 1;
        end else begin
            stride_pos++;
        end
    endtask

    task automatic check_mean(input logic [OUT_W-1:0] word);
        mean_result_t              want;
        logic [DATA_WIDTH_DEF-1:0] got_mean;
        logic [POS_W-1:0]          got_pos;
        got_mean = word[DATA_WIDTH_DEF-1:0];
        got_pos = word[DATA_WIDTH_DEF +: POS_W];
        if (expected_means.size() == 0) begin
            report_mismatch($sformatf("unexpected mean %0d at position %0d",
                                      $signed(got_mean), got_pos));
            return;
        end
        want = expected_means.pop_front();
        means_checked++;
        if (got_mean !== want.mean)
            report_mismatch($sformatf("mean at position %0d: got %0d, want %0d",
                                      want.pos, $signed(got_mean), $signed(want.mean)));
        if (got_pos !== want.pos)
            report_mismatch($sformatf("stride position: got %0d, want %0d",
                                      got_pos, want.pos));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            stride_setting = STRIDE_RAW_W'(1);
            axis_setting = AXIS_RAW_W'(1);
            stride_pos = 0;
            row_pos = 0;
            mismatches = 0;
            means_checked = 0;
            expected_means.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                predict_mean(s_axis_tdata[DATA_WIDTH_DEF-1:0]);
            if (m_axis_tvalid && m_axis_tready)
                check_mean(m_axis_tdata);
        end
        outstanding <= expected_means.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the axis_mean_reducer test: clock, reset, sample and register stimulus
// with random stalls on both channels, and the verdict.
// Depends on amr_pkg, axis_mean_reducer and mean_checker.
module testbench;
    import amr_pkg::*;

    localparam int IN_W          = ((DATA_WIDTH_DEF + 7) / 8) * 8;
    localparam int OUT_W         = ((DATA_WIDTH_DEF + $clog2(MAX_STRIDE_DEF) + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 400;
    localparam int LONG_AXIS     = 200;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam logic [DATA_WIDTH_DEF-1:0] MAX_WORD = 32'h7FFF_FFFF;
    localparam logic [DATA_WIDTH_DEF-1:0] MIN_WORD = 32'h8000_0000;

    typedef enum int {
        FILL_FULL,
        FILL_EXTREME,
        FILL_SMALL
    } fill_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;   // sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;        // mean_value, stride_position
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int  mismatches;
    int  outstanding;
    int  means_checked;
    int  cycle_count = 0;
    int  samples_sent = 0;
    int  reg_writes = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_stalls = 1'b1;
    int  rx_hold_req = 0;
    int  rx_holds_done = 0;
    int  rx_wait = 0;

    axis_mean_reducer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mean_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .means_checked (means_checked)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return $urandom_range(20, 90);
        if (r < 50)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    // Result side: random stalls, plus a long hold whenever one is requested.
    always @(posedge aclk) begin : rx_pace
        int g;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else if (rx_holds_done < rx_hold_req) begin
            m_axis_tready <= 1'b0;
            rx_wait <= HOLD_CYCLES;
            rx_holds_done <= rx_holds_done + 1;
        end else if (rx_stalls && $urandom_range(0, 1) == 0) begin
            g = gap_len();
            m_axis_tready <= (g == 0);
            rx_wait <= (g > 0) ? g - 1 : 0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [CFG_DATA_W-1:0] cfg_word(input logic [CFG_IDX_W-1:0] idx,
                                                       input int value);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom);
        // Bits above the register width are don't-care, so keep them random.
        if (idx == CFG_INNER_STRIDE)
            w[STRIDE_RAW_W-1:0] = STRIDE_RAW_W'(value);
        else if (idx == CFG_AXIS_LENGTH)
            w[AXIS_RAW_W-1:0] = AXIS_RAW_W'(value);
        return w;
    endfunction

    function automatic logic [DATA_WIDTH_DEF-1:0] next_word(input fill_t fill);
        int v;
        case (fill)
            FILL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return MAX_WORD;
                    1: return MIN_WORD;
                    2: return '0;
                    default: return '1;
                endcase
            end
            FILL_SMALL: begin
                v = $urandom_range(0, 32'h8_0000);
                return v - 32'h4_0000;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 4);
        if (r < 85)
            return $urandom_range(5, 16);
        return $urandom_range(17, 96);
    endfunction

    task automatic send_word(input logic [DATA_WIDTH_DEF-1:0] word);
        int gap;
        gap = tx_gaps ? gap_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= $urandom;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        do @(posedge aclk); while (!s_axis_tready);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge aclk);
    endtask

    // Stop the input and wait until every mean is out and the block is idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int    stride;
        int    axis;
        int    count;
        int    random_items;
        fill_t fill;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting is a pass-through: every beat is its own mean.
        send_word(MAX_WORD);
        send_word(MIN_WORD);
        send_word('0);
        send_word('1);
        send_word(32'h0000_0001);
        send_word(32'h0001_0000);

        // Sums wider than the sample, and halves that truncate toward zero.
        settle();
        write_reg(CFG_INNER_STRIDE, cfg_word(CFG_INNER_STRIDE, 2));
        write_reg(CFG_AXIS_LENGTH, cfg_word(CFG_AXIS_LENGTH, 2));
        send_word(MIN_WORD);
        send_word(MAX_WORD);
        send_word(MIN_WORD);
        send_word(MAX_WORD);
        send_word(-1);
        send_word(3);
        send_word(0);
        send_word(-4);

        // A write to an unused index mid-block must leave the counters alone.
        send_word(5);
        send_word(7);
        send_word(-6);
        settle();
        write_reg(CFG_IDX_W'(CFG_AXIS_LENGTH + 1), 16'hFFFF);
        send_word(9);

        // A block left incomplete, then zero settings acting as one.
        send_word(11);
        settle();
        write_reg(CFG_INNER_STRIDE, cfg_word(CFG_INNER_STRIDE, 0));
        write_reg(CFG_AXIS_LENGTH, cfg_word(CFG_AXIS_LENGTH, 0));
        send_word(-7);
        send_word(7);

        // Negative mean that must not round down.
        settle();
        write_reg(CFG_INNER_STRIDE, cfg_word(CFG_INNER_STRIDE, 1));
        write_reg(CFG_AXIS_LENGTH, cfg_word(CFG_AXIS_LENGTH, 3));
        send_word(-1);
        send_word(-1);
        send_word(-2);

        // Back-pressure: the result side holds off while beats keep coming.
        settle();
        write_reg(CFG_AXIS_LENGTH, cfg_word(CFG_AXIS_LENGTH, 1));
        rx_hold_req <= rx_hold_req + 1;
        repeat (40) send_word($urandom);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            stride = pick_extent();
            axis = pick_extent();
            while (stride * axis > 192)
                axis = (axis + 1) / 2;
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_AXIS_LENGTH + 1, 255)),
                          CFG_DATA_W'($urandom));
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_INNER_STRIDE, cfg_word(CFG_INNER_STRIDE,
                    (stride == 1 && $urandom_range(0, 2) == 0) ? 0 : stride));
                write_reg(CFG_AXIS_LENGTH, cfg_word(CFG_AXIS_LENGTH,
                    (axis == 1 && $urandom_range(0, 2) == 0) ? 0 : axis));
            end else begin
                write_reg(CFG_AXIS_LENGTH, cfg_word(CFG_AXIS_LENGTH,
                    (axis == 1 && $urandom_range(0, 2) == 0) ? 0 : axis));
                write_reg(CFG_INNER_STRIDE, cfg_word(CFG_INNER_STRIDE,
                    (stride == 1 && $urandom_range(0, 2) == 0) ? 0 : stride));
            end
            count = $urandom_range(1, 4) * stride * axis;
            if (stride * axis > 1 && $urandom_range(0, 3) == 0)
                count += $urandom_range(1, stride * axis - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: fill = FILL_FULL;
                6, 7:             fill = FILL_EXTREME;
                default:          fill = FILL_SMALL;
            endcase
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls <= ($urandom_range(0, 3) != 0);
            repeat (count) send_word(next_word(fill));
            random_items += count;
        end

        // Back to back: an oversized stride that sweeps every accumulator,
        // then a long axis of the most negative value for a wide sum.
        settle();
        tx_gaps = 1'b0;
        rx_stalls <= 1'b0;
        write_reg(CFG_AXIS_LENGTH, cfg_word(CFG_AXIS_LENGTH, 1));
        write_reg(CFG_INNER_STRIDE, cfg_word(CFG_INNER_STRIDE, 2047));
        repeat (MAX_STRIDE_DEF) send_word($urandom);
        settle();
        write_reg(CFG_INNER_STRIDE, cfg_word(CFG_INNER_STRIDE, 1));
        write_reg(CFG_AXIS_LENGTH, cfg_word(CFG_AXIS_LENGTH, LONG_AXIS));
        repeat (LONG_AXIS) send_word(MIN_WORD);

        settle();
        $display("Streamed %0d samples under %0d register writes; %0d means compared.",
                 samples_sent, reg_writes, means_checked);
        $display("Strides from 1 to 1024 and axis lengths from 1 to 200, with stalls.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
